// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C master register transfer sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned LEN_W     = 9;
    localparam int unsigned TICK_W    = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd10000;

    // result queue
    localparam int unsigned Q_DEPTH   = 8;
    localparam int unsigned Q_AW      = 3;
    localparam int unsigned MAX_RES   = 3;

    // register map
    localparam int unsigned PADDR_W   = 3;
    localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = 3'd0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_DONE  = 3'd2,
        OP_NACK  = 3'd3,
        OP_BYTE  = 3'd4,
        OP_TICK  = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAIT_FREE = 4'd1,
        PH_START     = 4'd2,
        PH_ADDR_W    = 4'd3,
        PH_REG       = 4'd4,
        PH_DATA      = 4'd5,
        PH_RSTART    = 4'd6,
        PH_ADDR_R    = 4'd7,
        PH_RECV      = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_START   = 4'd1,
        ACT_SEND    = 4'd2,
        ACT_RX_ACK  = 4'd3,
        ACT_RX_NACK = 4'd4,
        ACT_STOP    = 4'd5,
        ACT_READ    = 4'd6,
        ACT_DONE    = 4'd7,
        ACT_ERROR   = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_NACK    = 2'd1,
        ERR_TIMEOUT = 2'd2,
        ERR_ZERO    = 2'd3
    } t_err;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [6:0]       device_address;
        logic [7:0]       register_address;
        logic [7:0]       write_data;
        logic [LEN_W-1:0] read_length;
        logic [7:0]       received_byte;
        logic             bus_busy;
    } t_in_item;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] byte_value;
        logic [1:0] error_kind;
        logic       last_of_run;
    } t_out_item;

endpackage

// File: rtl/i2c_master_register_transfer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// Byte-level I2C master sequencer for register writes and register reads
// with repeated start, not-acknowledge and tick timeout handling.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall     i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall   o_out_item (t_out_item)
//  config    in         APB psel/penable/pwrite    timeout_limit at 0x0
//
//  One input transfer per cycle is taken while the result queue has room for
//  three results; the phase register update and all results are computed in
//  that same cycle and pushed into an 8-entry result queue.
//  The output drains one result per cycle, so the queue port sets the rate.
//  Synchronous active-low reset: phase idle, queue empty, timeout 10000.
//  Output stall backs up the queue; input stalls once fewer than three slots
//  are free.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer
    import i2cm_pkg::*;
#(
    parameter int MAX_READ_LEN = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // state
    t_phase            r_phase,   n_phase;
    logic              r_is_read, n_is_read;
    logic [6:0]        r_dev,     n_dev;
    logic [7:0]        r_reg,     n_reg;
    logic [7:0]        r_data,    n_data;
    logic [LEN_W-1:0]  r_left,    n_left;
    logic [TICK_W-1:0] r_wait,    n_wait;
    logic [TICK_W-1:0] r_limit;

    t_out_item         r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_cnt;

    logic              in_acc, out_pop, cfg_wr;
    logic [TICK_W:0]   wait_inc, eff_limit;
    logic              tick_hit, tick_free, active;
    logic [LEN_W-1:0]  len_sat, left_dec;
    logic [7:0]        addr_w, addr_r;
    logic              len_zero;
    t_out_item         res [MAX_RES];
    logic [1:0]        n_res;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_pop = o_out_valid && !i_out_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // ------------------------------------------------------------------
    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIMEOUT) ? {16'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TIMEOUT_RESET;
        end else if (cfg_wr && paddr == ADDR_TIMEOUT) begin
            r_limit <= pwdata[TICK_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // shared decode
    assign len_zero = (i_in_item.operation == OP_READ) && (i_in_item.read_length == '0);
    assign active   = (r_phase != PH_IDLE) && (r_phase != PH_WAIT_FREE);

    // a zero limit acts as one
    assign wait_inc  = {1'b0, r_wait} + 17'd1;
    assign eff_limit = (r_limit == '0) ? 17'd1 : {1'b0, r_limit};
    assign tick_hit  = (wait_inc >= eff_limit);
    assign tick_free = (r_phase == PH_WAIT_FREE) && !i_in_item.bus_busy;

    assign len_sat  = ({8'd0, i_in_item.read_length} > 17'(MAX_READ_LEN))
                    ? LEN_W'(MAX_READ_LEN) : i_in_item.read_length;
    assign left_dec = (r_left != '0) ? r_left - 9'd1 : r_left;
    assign addr_w   = {r_dev, 1'b0};
    assign addr_r   = {r_dev, 1'b1};

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_left    = r_left;
        n_wait    = r_wait;
        unique case (i_in_item.operation)
            OP_WRITE, OP_READ: begin
                if (r_phase == PH_IDLE && !len_zero) begin
                    n_is_read = (i_in_item.operation == OP_READ);
                    n_dev     = i_in_item.device_address;
                    n_reg     = i_in_item.register_address;
                    n_data    = i_in_item.write_data;
                    n_left    = (i_in_item.operation == OP_READ) ? len_sat : '0;
                    n_wait    = '0;
                    n_phase   = i_in_item.bus_busy ? PH_WAIT_FREE : PH_START;
                end
            end
            OP_DONE: begin
                n_wait = active ? '0 : r_wait;
                unique case (r_phase)
                    PH_START:  n_phase = PH_ADDR_W;
                    PH_ADDR_W: n_phase = PH_REG;
                    PH_REG:    n_phase = r_is_read ? PH_RSTART : PH_DATA;
                    PH_DATA:   n_phase = PH_IDLE;
                    PH_RSTART: n_phase = PH_ADDR_R;
                    PH_ADDR_R: n_phase = PH_RECV;
                    default: begin
                        n_phase = r_phase;
                        n_wait  = r_wait;
                    end
                endcase
            end
            OP_NACK: begin
                if (active) begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
            OP_BYTE: begin
                if (r_phase == PH_RECV) begin
                    n_left  = left_dec;
                    n_wait  = '0;
                    n_phase = (left_dec == '0) ? PH_IDLE : PH_RECV;
                end
            end
            OP_TICK: begin
                if (tick_free) begin
                    n_wait  = '0;
                    n_phase = PH_START;
                end else if (r_phase != PH_IDLE) begin
                    if (tick_hit) begin
                        n_wait  = '0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait  = wait_inc[TICK_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // results of this transfer
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        n_res = 2'd0;
        unique case (i_in_item.operation)
            OP_WRITE, OP_READ: begin
                if (r_phase == PH_IDLE) begin
                    if (len_zero) begin
                        res[0].action     = ACT_ERROR;
                        res[0].error_kind = ERR_ZERO;
                        n_res = 2'd1;
                    end else if (!i_in_item.bus_busy) begin
                        res[0].action = ACT_START;
                        n_res = 2'd1;
                    end
                end
            end
            OP_DONE: begin
                unique case (r_phase)
                    PH_START: begin
                        res[0].action     = ACT_SEND;
                        res[0].byte_value = addr_w;
                        n_res = 2'd1;
                    end
                    PH_ADDR_W: begin
                        res[0].action     = ACT_SEND;
                        res[0].byte_value = r_reg;
                        n_res = 2'd1;
                    end
                    PH_REG: begin
                        if (r_is_read) begin
                            res[0].action = ACT_START;
                        end else begin
                            res[0].action     = ACT_SEND;
                            res[0].byte_value = r_data;
                        end
                        n_res = 2'd1;
                    end
                    PH_DATA: begin
                        res[0].action = ACT_STOP;
                        res[1].action = ACT_DONE;
                        n_res = 2'd2;
                    end
                    PH_RSTART: begin
                        res[0].action     = ACT_SEND;
                        res[0].byte_value = addr_r;
                        n_res = 2'd1;
                    end
                    PH_ADDR_R: begin
                        res[0].action = (r_left <= 9'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                        n_res = 2'd1;
                    end
                    default: ;
                endcase
            end
            OP_NACK: begin
                if (active) begin
                    res[0].action     = ACT_STOP;
                    res[1].action     = ACT_ERROR;
                    res[1].error_kind = ERR_NACK;
                    n_res = 2'd2;
                end
            end
            OP_BYTE: begin
                if (r_phase == PH_RECV) begin
                    res[0].action     = ACT_READ;
                    res[0].byte_value = i_in_item.received_byte;
                    if (left_dec == '0) begin
                        res[1].action = ACT_STOP;
                        res[2].action = ACT_DONE;
                        n_res = 2'd3;
                    end else begin
                        res[1].action = (left_dec == 9'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                        n_res = 2'd2;
                    end
                end
            end
            OP_TICK: begin
                if (tick_free) begin
                    res[0].action = ACT_START;
                    n_res = 2'd1;
                end else if (r_phase != PH_IDLE && tick_hit) begin
                    // a bus that never frees gives the error alone, no stop
                    if (r_phase == PH_WAIT_FREE) begin
                        res[0].action     = ACT_ERROR;
                        res[0].error_kind = ERR_TIMEOUT;
                        n_res = 2'd1;
                    end else begin
                        res[0].action     = ACT_STOP;
                        res[1].action     = ACT_ERROR;
                        res[1].error_kind = ERR_TIMEOUT;
                        n_res = 2'd2;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < MAX_RES; k++) begin
            res[k].last_of_run = (2'(k) == n_res - 2'd1) && (n_res != 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_data    <= '0;
            r_left    <= '0;
            r_wait    <= '0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_left    <= n_left;
            r_wait    <= n_wait;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    assign o_in_stall  = (r_cnt > (Q_AW+1)'(Q_DEPTH - MAX_RES));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < n_res) begin
                    r_q[r_wr + Q_AW'(k)] <= res[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_acc) begin
                r_wr <= r_wr + Q_AW'(n_res);
            end
            if (out_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + ((in_acc) ? (Q_AW+1)'(n_res) : '0)
                           - ((Q_AW+1)'(out_pop));
        end
    end

    // ------------------------------------------------------------------
    // assertions
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_pop && r_cnt == 1) |-> o_out_item.last_of_run)
        else $error("queue drained mid-run");

    a_recv_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RECV) |-> (r_left != '0))
        else $error("receiving with no bytes left");

    a_free_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_IDLE && i_in_item.operation == OP_WRITE
         && !i_in_item.bus_busy) |=> (r_phase == PH_START))
        else $error("write on free bus did not start");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.operation == OP_TICK && r_phase != PH_IDLE
         && !tick_free && tick_hit) |=> (r_phase == PH_IDLE && r_wait == '0))
        else $error("timeout did not abort");

endmodule
